// File: design/irrigation_zone_controller_unit_assert.svh
// assertion macros for the irrigation zone controller checker
// depends on nothing; taken in by the checker file through include
`ifndef IRRIGATION_ZONE_CONTROLLER_UNIT_ASSERT_SVH
`define IRRIGATION_ZONE_CONTROLLER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define IZC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on the rising clock, off during reset
`define IZC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/izc_pkg.sv
// shared types and constants of the irrigation zone controller
// no dependencies; used by the lanes, the merge stage, the top level and the checker
package izc_pkg;

    localparam int N_ZONES     = 4;
    localparam int RAW_W       = 10;
    localparam int PCT_W       = 7;
    localparam int THR_W       = 8;
    localparam int ZONE_W      = 3;
    localparam int NOW_W       = 32;
    localparam int BLINK_W     = 16;
    localparam int PCT_SCALE   = 100;
    localparam int ADC_MAX_DEF = 1023;

    // configuration port
    localparam int APB_DW  = 32;
    localparam int PADDR_W = 5;
    localparam int REG_IW  = 3;

    localparam logic [REG_IW-1:0] REG_ZONE_MASK = 3'd0;
    localparam logic [REG_IW-1:0] REG_THR_Z1    = 3'd1;
    localparam logic [REG_IW-1:0] REG_THR_Z2    = 3'd2;
    localparam logic [REG_IW-1:0] REG_THR_Z3    = 3'd3;
    localparam logic [REG_IW-1:0] REG_THR_Z4    = 3'd4;
    localparam logic [REG_IW-1:0] REG_LVL_CHK   = 3'd5;
    localparam logic [REG_IW-1:0] REG_BLINK     = 3'd6;

    localparam logic [THR_W-1:0]   THR_RST   = 8'd50;
    localparam logic [BLINK_W-1:0] BLINK_RST = 16'd1000;

    // stream payloads
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 40;

    typedef logic [N_ZONES-1:0][PCT_W-1:0] t_pct_vec;
    typedef logic [N_ZONES-1:0][THR_W-1:0] t_thr_vec;

    // per-stage load enables of the lane pipeline
    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } t_pipe_ctl;

endpackage

// File: design/irrigation_zone_controller_unit.sv
// irrigation zone controller: each input transfer is one control tick carrying four
// moisture samples, the tank level bit and a millisecond timestamp. four identical lanes
// turn the samples into percent ((ADC_MAX - raw) * 100 / ADC_MAX, truncated, samples above
// ADC_MAX read as 0 percent) through a three-stage reciprocal multiply; a merge stage then
// picks the lowest enabled zone below its threshold, applies the low tank lockout, runs the
// warning led blink timer and registers the result. one result transfer per input transfer,
// in order. throughput is one tick per clock unless m_axis_tready stalls; each tick
// runs through three lane stages and the result register. stages advance independently,
// so input is still taken while a result waits, until all four stages hold a tick.
// configuration registers sit on an apb port at byte addresses 4*i, pready always high,
// and are to be written only while no tick is in flight. no clearing pass after reset.
// depends on izc_pkg, izc_lane, izc_merge
module irrigation_zone_controller_unit
    import izc_pkg::*;
#(
    parameter int ADC_MAX = ADC_MAX_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    // ticks in
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // raw_moisture_1 [9:0], raw_moisture_2 [19:10], raw_moisture_3 [29:20],
    // raw_moisture_4 [39:30], tank_level_ok [40], now_ms [72:41], zero pad [79:73]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,

    // results out
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // pump_on [0], active_zone [3:1], warning_led [4], water_low [5],
    // moisture_pct_1 [12:6], moisture_pct_2 [19:13], moisture_pct_3 [26:20],
    // moisture_pct_4 [33:27], zero pad [39:34]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,

    // configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [APB_DW-1:0]      pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    // configuration registers
    logic [N_ZONES-1:0] r_zone_mask;
    t_thr_vec           r_thr;
    logic               r_lvl_chk;
    logic [BLINK_W-1:0] r_blink;

    logic               cfg_wr;
    logic [REG_IW-1:0]  reg_idx;

    // pipeline valids and enables
    logic      r_v1;
    logic      r_v2;
    logic      r_v3;
    logic      r_ov;
    logic      en_out;
    t_pipe_ctl ctl;

    // tick side data traveling with the lanes
    logic             r_tank1;
    logic             r_tank2;
    logic             r_tank3;
    logic [NOW_W-1:0] r_now1;
    logic [NOW_W-1:0] r_now2;
    logic [NOW_W-1:0] r_now3;

    logic [N_ZONES-1:0][RAW_W-1:0] raw;
    t_pct_vec                      lane_pct;

    logic              res_pump;
    logic [ZONE_W-1:0] res_zone;
    logic              res_led;
    logic              res_low;
    t_pct_vec          res_pct;

    // ---------------------------------------------------------------- apb
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone_mask <= '0;
            r_thr       <= {N_ZONES{THR_RST}};
            r_lvl_chk   <= 1'b0;
            r_blink     <= BLINK_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_ZONE_MASK: r_zone_mask <= pwdata[N_ZONES-1:0];
                REG_THR_Z1:    r_thr[0]    <= pwdata[THR_W-1:0];
                REG_THR_Z2:    r_thr[1]    <= pwdata[THR_W-1:0];
                REG_THR_Z3:    r_thr[2]    <= pwdata[THR_W-1:0];
                REG_THR_Z4:    r_thr[3]    <= pwdata[THR_W-1:0];
                REG_LVL_CHK:   r_lvl_chk   <= pwdata[0];
                REG_BLINK:     r_blink     <= pwdata[BLINK_W-1:0];
                default: ;  // unmapped address, write dropped
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_ZONE_MASK: prdata = APB_DW'(r_zone_mask);
            REG_THR_Z1:    prdata = APB_DW'(r_thr[0]);
            REG_THR_Z2:    prdata = APB_DW'(r_thr[1]);
            REG_THR_Z3:    prdata = APB_DW'(r_thr[2]);
            REG_THR_Z4:    prdata = APB_DW'(r_thr[3]);
            REG_LVL_CHK:   prdata = APB_DW'(r_lvl_chk);
            REG_BLINK:     prdata = APB_DW'(r_blink);
            default:       prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- flow control
    // a stage loads when it is empty or its content moves on, so bubbles collapse
    assign en_out        = !r_ov || m_axis_tready;
    assign ctl.en3       = !r_v3 || en_out;
    assign ctl.en2       = !r_v2 || ctl.en3;
    assign ctl.en1       = !r_v1 || ctl.en2;
    assign s_axis_tready = ctl.en1;
    assign m_axis_tvalid = r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (ctl.en1) begin
                r_v1 <= s_axis_tvalid;
            end
            if (ctl.en2) begin
                r_v2 <= r_v1;
            end
            if (ctl.en3) begin
                r_v3 <= r_v2;
            end
            if (en_out) begin
                r_ov <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.en1) begin
            r_tank1 <= s_axis_tdata[40];
            r_now1  <= s_axis_tdata[72:41];
        end
        if (ctl.en2) begin
            r_tank2 <= r_tank1;
            r_now2  <= r_now1;
        end
        if (ctl.en3) begin
            r_tank3 <= r_tank2;
            r_now3  <= r_now2;
        end
    end

    // ---------------------------------------------------------------- lanes
    genvar g;
    generate
        for (g = 0; g < N_ZONES; g++) begin : g_lane
            assign raw[g] = s_axis_tdata[g*RAW_W +: RAW_W];

            izc_lane #(
                .ADC_MAX (ADC_MAX)
            ) u_lane (
                .i_clk (i_clk),
                .i_ctl (ctl),
                .i_raw (raw[g]),
                .o_pct (lane_pct[g])
            );
        end
    endgenerate

    // ---------------------------------------------------------------- merge
    // blink state advances only when a tick enters the result register, in tick order
    izc_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (en_out && r_v3),
        .i_pct       (lane_pct),
        .i_tank      (r_tank3),
        .i_now       (r_now3),
        .i_zone_mask (r_zone_mask),
        .i_thr       (r_thr),
        .i_lvl_chk   (r_lvl_chk),
        .i_blink     (r_blink),
        .o_pump      (res_pump),
        .o_zone      (res_zone),
        .o_led       (res_led),
        .o_low       (res_low),
        .o_pct       (res_pct)
    );

    assign m_axis_tdata = {6'd0, res_pct[3], res_pct[2], res_pct[1], res_pct[0],
                           res_low, res_led, res_zone, res_pump};

endmodule

// File: design/izc_lane.sv
// one moisture lane: raw adc sample to truncated percent in three stages
// depends on izc_pkg
module izc_lane
    import izc_pkg::*;
#(
    parameter int ADC_MAX = ADC_MAX_DEF
) (
    input  logic             i_clk,
    input  t_pipe_ctl        i_ctl,
    input  logic [RAW_W-1:0] i_raw,
    output logic [PCT_W-1:0] o_pct
);

    localparam int DW    = $clog2(ADC_MAX + 1);
    localparam int CW    = (DW > RAW_W) ? DW : RAW_W;
    localparam int VW    = $clog2(ADC_MAX * PCT_SCALE + 1);
    localparam int SH    = VW;
    localparam int RECIP = (1 << SH) / ADC_MAX;
    localparam int MW    = $clog2(RECIP + 1);
    localparam int PW    = VW + MW;

    logic [CW-1:0]    raw_ext;
    logic [CW-1:0]    raw_clip;
    logic [DW-1:0]    diff;
    logic [VW-1:0]    n_v1;
    logic [VW-1:0]    r_v1;
    logic [VW-1:0]    r_v2;
    logic [PW-1:0]    r_prod;
    logic [PCT_W-1:0] q_est;
    logic [VW-1:0]    q_mul;
    logic [VW-1:0]    rem;
    logic [PCT_W-1:0] n_pct;
    logic [PCT_W-1:0] r_pct;

    // stage 1: clip to full scale, scale by 100
    always_comb begin
        raw_ext  = CW'(i_raw);
        raw_clip = (raw_ext > CW'(ADC_MAX)) ? CW'(ADC_MAX) : raw_ext;
        diff     = DW'(CW'(ADC_MAX) - raw_clip);
        n_v1     = VW'(diff * PCT_SCALE);
    end

    // stage 3: reciprocal estimate is exact or one low, fix with one compare
    always_comb begin
        q_est = r_prod[SH+PCT_W-1:SH];
        q_mul = VW'(q_est * ADC_MAX);
        rem   = r_v2 - q_mul;
        n_pct = (rem >= VW'(ADC_MAX)) ? q_est + PCT_W'(1) : q_est;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en1) begin
            r_v1 <= n_v1;
        end
        if (i_ctl.en2) begin
            r_v2   <= r_v1;
            r_prod <= PW'(r_v1) * PW'(RECIP);
        end
        if (i_ctl.en3) begin
            r_pct <= n_pct;
        end
    end

    assign o_pct = r_pct;

endmodule

// File: design/izc_merge.sv
// merge stage: zone priority pick, tank lockout, warning led state, result register
// depends on izc_pkg
module izc_merge
    import izc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  t_pct_vec           i_pct,
    input  logic               i_tank,
    input  logic [NOW_W-1:0]   i_now,
    input  logic [N_ZONES-1:0] i_zone_mask,
    input  t_thr_vec           i_thr,
    input  logic               i_lvl_chk,
    input  logic [BLINK_W-1:0] i_blink,
    output logic               o_pump,
    output logic [ZONE_W-1:0]  o_zone,
    output logic               o_led,
    output logic               o_low,
    output t_pct_vec           o_pct
);

    logic [N_ZONES-1:0] qual;
    logic [ZONE_W-1:0]  sel;
    logic               usable;
    logic [NOW_W-1:0]   elapsed;
    logic               n_led;
    logic [NOW_W-1:0]   n_last;
    logic               n_pump;
    logic [ZONE_W-1:0]  n_zone;

    logic               r_led;
    logic [NOW_W-1:0]   r_last;
    logic               r_pump;
    logic [ZONE_W-1:0]  r_zone;
    logic               r_low;
    t_pct_vec           r_pct;

    // lowest numbered qualifying zone wins
    always_comb begin
        sel = '0;
        for (int i = N_ZONES - 1; i >= 0; i--) begin
            qual[i] = i_zone_mask[i] && (THR_W'(i_pct[i]) < i_thr[i]);
            if (qual[i]) begin
                sel = ZONE_W'(i + 1);
            end
        end
    end

    always_comb begin
        usable  = i_tank || !i_lvl_chk;
        elapsed = i_now - r_last;
        n_led   = r_led;
        n_last  = r_last;
        if (usable) begin
            n_led = 1'b0;
        end else if (elapsed > NOW_W'(i_blink)) begin
            n_led  = !r_led;
            n_last = i_now;
        end
        n_pump = usable && (sel != '0);
        n_zone = usable ? sel : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led  <= 1'b0;
            r_last <= '0;
        end else if (i_load) begin
            r_led  <= n_led;
            r_last <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pump <= n_pump;
            r_zone <= n_zone;
            r_low  <= !usable;
            r_pct  <= i_pct;
        end
    end

    assign o_pump = r_pump;
    assign o_zone = r_zone;
    assign o_led  = r_led;
    assign o_low  = r_low;
    assign o_pct  = r_pct;

endmodule

// File: design/izc_checker.sv
// port-level checker of the irrigation zone controller, bound to the top level
// depends on izc_pkg and irrigation_zone_controller_unit_assert.svh
`include "irrigation_zone_controller_unit_assert.svh"

module izc_checker
    import izc_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] i_m_tdata
);

    // a stalled result stays offered
    `IZC_ASSERT_NEXT(a_hold_valid, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid, "result dropped while stalled")

    // pump runs exactly when a valve is open
    `IZC_ASSERT_NOW(a_pump_zone, i_clk, i_rst_n, i_m_tvalid, i_m_tdata[0] == (i_m_tdata[3:1] != 3'd0), "pump and valve disagree")

    // lockout stops the pump
    `IZC_ASSERT_NOW(a_low_stop, i_clk, i_rst_n, i_m_tvalid && i_m_tdata[5], !i_m_tdata[0], "pump on during low tank lockout")

    // led is dark whenever the tank is usable
    `IZC_ASSERT_NOW(a_led_dark, i_clk, i_rst_n, i_m_tvalid && !i_m_tdata[5], !i_m_tdata[4], "warning led lit with usable tank")

    // zone number stays within the four valves
    `IZC_ASSERT_NOW(a_zone_range, i_clk, i_rst_n, i_m_tvalid, i_m_tdata[3:1] <= 3'd4, "zone number out of range")

endmodule

bind irrigation_zone_controller_unit izc_checker u_izc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata)
);
